[rtl/sct_pkg.sv]
// Shared types and constants for the sorted client table.
// Used by sct_ctrl, sct_datapath, sorted_client_table and the testbench; depends on nothing.
`default_nettype none

package sct_pkg;

   // Widths of the word fields as they appear on the ports.
   localparam int REQ_W       = 2;
   localparam int IN_KEY_W    = 32;
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 7;
   localparam int RSP_DATA_W  = 24;

   // Request kinds carried on req_tuser.
   localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ATTACH  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DISCARD = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_GONE      = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                search_rd;
      logic                search_cmp;
      logic                ins_init;
      logic                del_init;
      logic                shift_rd_up;
      logic                shift_wr_up;
      logic                write_key;
      logic                shift_rd_dn;
      logic                shift_wr_dn;
      logic                count_inc;
      logic                count_dec;
      logic                result;
      logic [STATUS_W-1:0] result_status;
      logic                result_use_pos;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic search_done;
      logic found;
      logic full;
      logic at_pos;
      logic at_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/sct_datapath.sv]
// Datapath of the sorted client table: key memory, search bounds, sweep index,
// entry count and the result register. Depends on sct_pkg.
`default_nettype none

module sct_datapath #(
   parameter int MAX_CLIENTS = 64,
   parameter int KEY_WIDTH   = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sct_pkg::cmd_type               cmd,
   output sct_pkg::stat_type                   stat,
   input  wire logic [sct_pkg::IN_KEY_W-1:0]   req_tdata,
   input  wire logic                           rsp_tready,
   output logic                                rsp_tvalid,
   output logic [sct_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import sct_pkg::*;

   localparam int AW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
   localparam int CW = $clog2(MAX_CLIENTS + 1);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_CLIENTS);

   logic [KEY_WIDTH-1:0] mem [MAX_CLIENTS];

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] rd_data_ff;
   logic [CW-1:0]        lo_ff;
   logic [CW-1:0]        hi_ff;
   logic [CW-1:0]        mid_ff;
   logic [CW-1:0]        idx_ff;
   logic [CW-1:0]        count_ff;
   logic                 found_ff;
   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [KEY_WIDTH+IN_KEY_W-1:0] key_ext;
   logic [KEY_WIDTH-1:0]          key_in;
   logic [CW:0]                   mid_sum;
   logic [CW-1:0]                 mid;
   logic [CW-1:0]                 idx_dn;
   logic [CW-1:0]                 idx_up;
   logic [AW-1:0]                 rd_addr;
   logic [CW+POS_W-1:0]           pos_ext;
   logic [CW+POS_W-1:0]           cnt_ext;
   logic [RSP_DATA_W-1:0]         rsp_data_in;

   assign key_ext = {{KEY_WIDTH{1'b0}}, req_tdata};
   assign key_in  = key_ext[KEY_WIDTH-1:0];
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign idx_dn  = idx_ff - ONE;
   assign idx_up  = idx_ff + ONE;

   always_comb begin
      if (cmd.shift_rd_up) begin
         rd_addr = idx_dn[AW-1:0];
      end else if (cmd.shift_rd_dn) begin
         rd_addr = idx_up[AW-1:0];
      end else begin
         rd_addr = mid[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
      if (cmd.write_key) begin
         mem[idx_ff[AW-1:0]] <= key_ff;
      end else if (cmd.shift_wr_up || cmd.shift_wr_dn) begin
         mem[idx_ff[AW-1:0]] <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= key_in;
         lo_ff    <= '0;
         hi_ff    <= count_ff;
         found_ff <= 1'b0;
      end
      if (cmd.search_rd) begin
         mid_ff <= mid;
      end
      if (cmd.search_cmp) begin
         if (rd_data_ff < key_ff) begin
            lo_ff <= mid_ff + ONE;
         end else begin
            hi_ff <= mid_ff;
         end
         if (rd_data_ff == key_ff) begin
            found_ff <= 1'b1;
         end
      end
      if (cmd.ins_init) begin
         idx_ff <= count_ff;
      end else if (cmd.del_init) begin
         idx_ff <= lo_ff;
      end else if (cmd.shift_wr_up) begin
         idx_ff <= idx_dn;
      end else if (cmd.shift_wr_dn) begin
         idx_ff <= idx_up;
      end
   end

   assign pos_ext = {{POS_W{1'b0}}, (cmd.result_use_pos ? lo_ff : {CW{1'b0}})};
   assign cnt_ext = {{POS_W{1'b0}}, count_ff};
   assign rsp_data_in = {{(RSP_DATA_W - STATUS_W - 2 * POS_W){1'b0}},
                         cnt_ext[POS_W-1:0], pos_ext[POS_W-1:0], cmd.result_status};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.count_inc) begin
            count_ff <= count_ff + ONE;
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - ONE;
         end
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign stat.search_done = !(lo_ff < hi_ff);
   assign stat.found       = found_ff;
   assign stat.full        = (count_ff == MAX_COUNT);
   assign stat.at_pos      = (idx_ff == lo_ff);
   assign stat.at_last     = (idx_up == count_ff);
   assign stat.out_free    = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/sct_ctrl.sv]
// Controller of the sorted client table: sequences search, insert and remove
// sweeps and holds the server_present register. Depends on sct_pkg.
`default_nettype none

module sct_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [sct_pkg::REQ_W-1:0]   req_tuser,
   input  wire logic                        csr_we,
   input  wire logic                        csr_wdata,
   input  wire sct_pkg::stat_type           stat,
   output sct_pkg::cmd_type                 cmd
);
   import sct_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_COMPARE,
      S_DECIDE,
      S_INS_CHECK,
      S_INS_WRITE,
      S_DEL_CHECK,
      S_DEL_WRITE,
      S_REPLY
   } state_type;

   state_type           state_ff, state_in;
   logic [REQ_W-1:0]    req_type_ff;
   logic                server_ff;
   logic [STATUS_W-1:0] reply_status_ff, reply_status_in;
   logic                reply_pos_ff, reply_pos_in;

   always_comb begin
      state_in        = state_ff;
      reply_status_in = reply_status_ff;
      reply_pos_in    = reply_pos_ff;
      cmd             = '0;
      cmd.result_status  = reply_status_ff;
      cmd.result_use_pos = reply_pos_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (stat.search_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.search_rd = 1'b1;
               state_in      = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.search_cmp = 1'b1;
            state_in       = S_SEARCH;
         end
         S_DECIDE: begin
            reply_status_in = ST_NOT_FOUND;
            reply_pos_in    = 1'b0;
            state_in        = S_REPLY;
            case (req_type_ff)
               REQ_LOOKUP: begin
                  if (stat.found) begin
                     reply_status_in = ST_OK;
                     reply_pos_in    = 1'b1;
                  end
               end
               REQ_ATTACH: begin
                  if (stat.found) begin
                     reply_status_in = ST_PRESENT;
                     reply_pos_in    = 1'b1;
                  end else if (!server_ff) begin
                     reply_status_in = ST_GONE;
                  end else if (stat.full) begin
                     reply_status_in = ST_FULL;
                  end else begin
                     reply_status_in = ST_OK;
                     reply_pos_in    = 1'b1;
                     cmd.ins_init    = 1'b1;
                     state_in        = S_INS_CHECK;
                  end
               end
               REQ_DISCARD: begin
                  if (stat.found) begin
                     reply_status_in = ST_OK;
                     reply_pos_in    = 1'b1;
                     cmd.del_init    = 1'b1;
                     state_in        = S_DEL_CHECK;
                  end
               end
               default: begin
               end
            endcase
         end
         S_INS_CHECK: begin
            if (stat.at_pos) begin
               cmd.write_key = 1'b1;
               cmd.count_inc = 1'b1;
               state_in      = S_REPLY;
            end else begin
               cmd.shift_rd_up = 1'b1;
               state_in        = S_INS_WRITE;
            end
         end
         S_INS_WRITE: begin
            cmd.shift_wr_up = 1'b1;
            state_in        = S_INS_CHECK;
         end
         S_DEL_CHECK: begin
            if (stat.at_last) begin
               cmd.count_dec = 1'b1;
               state_in      = S_REPLY;
            end else begin
               cmd.shift_rd_dn = 1'b1;
               state_in        = S_DEL_WRITE;
            end
         end
         S_DEL_WRITE: begin
            cmd.shift_wr_dn = 1'b1;
            state_in        = S_DEL_CHECK;
         end
         S_REPLY: begin
            if (stat.out_free) begin
               cmd.result = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         server_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            server_ff <= csr_wdata;
         end
      end
      if (state_ff == S_IDLE && req_tvalid) begin
         req_type_ff <= req_tuser;
      end
      reply_status_ff <= reply_status_in;
      reply_pos_ff    <= reply_pos_in;
   end

endmodule

`default_nettype wire

[rtl/sorted_client_table.sv]
// Sorted client table: one request word in, one result word out. Each request runs a
// binary search of the key memory; an attach or a discard that changes the table adds
// a sweep over the key memory. One request is in work at a time: the block is ready for
// the next word in the cycle after the result word is loaded, and that load waits while
// an untaken result is still held.
// Reset clears the entry count and sets server_present; key memory is left unwritten.
`default_nettype none

module sorted_client_table #(
   parameter int MAX_CLIENTS = 64,
   parameter int KEY_WIDTH   = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel.
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // tdata: client_key [31:0].
   input  wire logic [sct_pkg::IN_KEY_W-1:0]  req_tdata,
   // tuser: req_type [1:0].
   input  wire logic [sct_pkg::REQ_W-1:0]     req_tuser,
   // Result channel.
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // tdata: status [2:0], position [9:3], entry_count [16:10], zeros above.
   output logic [sct_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration: server_present.
   input  wire logic                          csr_we,
   input  wire logic                          csr_wdata
);
   import sct_pkg::*;

   // The controller walks each request through a binary search of the key
   // memory, then, for an attach or a discard, through a sweep that moves the
   // later entries by one place. Each search step and each moved entry has a
   // read state, then a compare or write state; the read data is registered.
   cmd_type  cmd;
   stat_type stat;

   sct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .stat       (stat),
      .cmd        (cmd)
   );

   // The datapath holds the keys, the search bounds and the result register,
   // so a finished word can wait for rsp_tready while the next request is taken.
   sct_datapath #(
      .MAX_CLIENTS (MAX_CLIENTS),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[verif/sorted_client_table_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_client_table: a scoreboard class predicts each result word.
// Depends on sct_pkg and the sorted_client_table RTL only.

module sorted_client_table_test;
   import sct_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT = 600000;
   // The request kind that the block does not define; it must answer not found.
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   // One result word split into its fields.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [POS_W-1:0]    entry_count;
   } client_result_type;

   // Keeps its own ascending copy of the key table and the server flag, and queues
   // the result each accepted request word should produce.
   class client_table_scoreboard;
      logic [IN_KEY_W-1:0] held_keys[$];
      bit                  server_up;
      client_result_type   awaited[$];
      int                  mismatches;

      function new();
         server_up = 1'b1;
         mismatches = 0;
      endfunction

      function void set_server(bit up);
         server_up = up;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [IN_KEY_W-1:0] key);
         int                slot;
         bit                hit;
         client_result_type r;
         slot = 0;
         while (slot < held_keys.size() && held_keys[slot] < key)
            slot++;
         hit = (slot < held_keys.size()) && (held_keys[slot] == key);
         r.status = ST_NOT_FOUND;
         r.position = '0;
         case (kind)
            REQ_LOOKUP: begin
               if (hit) begin
                  r.status = ST_OK;
                  r.position = POS_W'(slot);
               end
            end
            REQ_ATTACH: begin
               if (hit) begin
                  r.status = ST_PRESENT;
                  r.position = POS_W'(slot);
               end else if (!server_up) begin
                  r.status = ST_GONE;
               end else if (held_keys.size() >= TABLE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  held_keys.insert(slot, key);
                  r.status = ST_OK;
                  r.position = POS_W'(slot);
               end
            end
            REQ_DISCARD: begin
               if (hit) begin
                  held_keys.delete(slot);
                  r.status = ST_OK;
                  r.position = POS_W'(slot);
               end
            end
            default: ;
         endcase
         r.entry_count = POS_W'(held_keys.size());
         awaited.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
         mismatches++;
      endtask

      task check_result(logic [RSP_DATA_W-1:0] word);
         client_result_type want;
         if (awaited.size() == 0) begin
            report_mismatch("result word with nothing outstanding", int'(word), -1);
         end else begin
            want = awaited.pop_front();
            if (word[2:0] !== want.status)
               report_mismatch("status", int'(word[2:0]), int'(want.status));
            if (word[9:3] !== want.position)
               report_mismatch("position", int'(word[9:3]), int'(want.position));
            if (word[16:10] !== want.entry_count)
               report_mismatch("entry_count", int'(word[16:10]), int'(want.entry_count));
            if (word[RSP_DATA_W-1:17] !== '0)
               report_mismatch("padding bits", int'(word[RSP_DATA_W-1:17]), 0);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_KEY_W-1:0]   req_tdata = '0;
   logic [REQ_W-1:0]      req_tuser = REQ_LOOKUP;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic                  csr_wdata = 1'b1;

   client_table_scoreboard sb;
   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   int  hold_left = 0;
   logic long_hold_req = 1'b0;
   logic long_hold_done = 1'b0;
   int  cycle_count = 0;

   sorted_client_table #(
      .MAX_CLIENTS(TABLE_DEPTH),
      .KEY_WIDTH  (32)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Watchdog. A hung handshake ends the run here with the failure line.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_client_table: mismatch");
         $finish;
      end
   end

   // Result receiver. It normally stalls at random at the current rate; once asked,
   // it holds off for a long stretch so the block backs up and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         hold_left <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Every result word accepted at this edge is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   // Offers one request word and waits until the block takes it. Valid is lowered
   // here only when a gap is inserted, so back-to-back words keep it high.
   task automatic send_word(input logic [REQ_W-1:0] kind, input logic [IN_KEY_W-1:0] key);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= key;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, key);
   endtask

   // The sender goes quiet until every predicted result has come back, then lets
   // the block settle before anything else happens.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_server_flag(input logic up);
      csr_we <= 1'b1;
      csr_wdata <= up;
      @(posedge clock);
      sb.set_server(up);
      csr_we <= 1'b0;
   endtask

   // Keys are mostly ones the table holds or their neighbors, so that hits,
   // duplicates and removals happen often; the rest are fresh or extreme values.
   function automatic logic [IN_KEY_W-1:0] pick_key();
      int          n;
      logic [31:0] k;
      n = sb.held_keys.size();
      case ($urandom_range(9)) inside
         [0:5]: k = (n > 0) ? sb.held_keys[$urandom_range(n - 1)] : $urandom();
         [6:7]: k = $urandom();
         8: begin
            case ($urandom_range(4))
               0: k = 32'h0000_0000;
               1: k = 32'hFFFF_FFFF;
               2: k = 32'h8000_0000;
               3: k = 32'h7FFF_FFFF;
               default: k = 32'h0000_0001;
            endcase
         end
         default: begin
            k = (n > 0) ? sb.held_keys[$urandom_range(n - 1)] : $urandom();
            k = $urandom_range(1) ? k + 32'd1 : k - 32'd1;
         end
      endcase
      return k;
   endfunction

   // A random mix of requests; half of the attaches bring a brand-new key.
   task automatic run_mix(input int count, input int attach_pct, input int discard_pct);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < attach_pct)
            send_word(REQ_ATTACH, $urandom_range(1) ? $urandom() : pick_key());
         else if (r < attach_pct + discard_pct)
            send_word(REQ_DISCARD, pick_key());
         else if (r < 95)
            send_word(REQ_LOOKUP, pick_key());
         else
            send_word(REQ_UNUSED, pick_key());
      end
   endtask

   // Attaches of fresh keys; enough of them run the table into the full case.
   task automatic run_fill(input int count);
      for (int i = 0; i < count; i++)
         send_word(REQ_ATTACH, $urandom());
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_server_flag(1'b1);

      // Directed part: empty table, ordered inserts at both ends and the middle,
      // duplicates, the unused kind, and attaches while the server is gone.
      send_word(REQ_LOOKUP, 32'h0000_0000);
      send_word(REQ_DISCARD, 32'h0000_0005);
      send_word(REQ_UNUSED, 32'hFFFF_FFFF);
      send_word(REQ_ATTACH, 32'hFFFF_FFFF);
      send_word(REQ_ATTACH, 32'h0000_0000);
      send_word(REQ_ATTACH, 32'h8000_0000);
      send_word(REQ_ATTACH, 32'h7FFF_FFFF);
      send_word(REQ_ATTACH, 32'h0000_0000);
      send_word(REQ_LOOKUP, 32'hFFFF_FFFF);
      send_word(REQ_LOOKUP, 32'h1234_5678);
      send_word(REQ_UNUSED, 32'h8000_0000);
      drain();
      write_server_flag(1'b0);
      // A held key is reported present even with the server gone.
      send_word(REQ_ATTACH, 32'h5555_AAAA);
      send_word(REQ_ATTACH, 32'h7FFF_FFFF);
      send_word(REQ_DISCARD, 32'h8000_0000);
      drain();
      write_server_flag(1'b1);
      send_word(REQ_ATTACH, 32'h8000_0000);
      send_word(REQ_DISCARD, 32'hFFFF_FFFF);
      send_word(REQ_DISCARD, 32'h0000_0000);
      send_word(REQ_DISCARD, 32'h0000_0000);
      send_word(REQ_LOOKUP, 32'h7FFF_FFFF);
      drain();

      // Sender idles lightly, receiver heavily.
      tx_idle_pct = 27;
      rx_idle_pct = 58;
      run_mix(100, 50, 20);
      run_fill(75);
      run_mix(20, 40, 0);
      drain();
      write_server_flag(1'b0);

      // Now the other way round; with the server gone the table only shrinks.
      tx_idle_pct = 58;
      rx_idle_pct = 27;
      run_mix(100, 35, 40);
      drain();
      write_server_flag(1'b1);
      // The receiver holds off for a long stretch while words keep coming.
      long_hold_req <= 1'b1;
      run_mix(80, 45, 25);
      drain();

      // No idling on either side.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      run_fill(70);
      run_mix(40, 30, 40);
      drain();
      write_server_flag(1'b0);
      run_mix(20, 50, 20);
      drain();
      write_server_flag(1'b1);
      run_mix(40, 10, 70);

      // Final wait: long enough for a stray word from a full-table sweep to show up.
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.awaited.size() != 0)
         sb.report_mismatch("results never delivered", 0, sb.awaited.size());
      if (sb.mismatches == 0) begin
         $display("sorted_client_table: match");
      end else begin
         $display("sorted_client_table: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/sct_pkg.sv
rtl/sct_datapath.sv
rtl/sct_ctrl.sv
rtl/sorted_client_table.sv
verif/sorted_client_table_test.sv
